// ===== design/srfh_pkg.sv =====
`timescale 1ns / 1ps

package srfh_pkg;

  // FNV-1a 64 constants
  localparam logic [63:0] FNV_OFFSET_BASIS = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIGHT_ROW_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PADDED_ROW_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd2;

  localparam logic [31:0] TIGHT_ROW_BYTES_RST = 32'd1;
  localparam logic [31:0] PADDED_ROW_BYTES_RST = 32'd256;
  localparam logic [31:0] ROW_COUNT_RST = 32'd1;

  // work queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [63:0] payload_hash;
    logic        length_mismatch;
  } result_t;

  // one classified byte on its way to the hash unit
  typedef struct packed {
    logic [7:0] data_byte;
    logic       hash_en;
    logic       last_byte;
    logic       length_mismatch;
  } work_t;

  // x * FNV_PRIME mod 2^64 as shifts and adds: prime = 2^40 + 2^8 + 0xb3
  function automatic logic [63:0] fnv_mul(input logic [63:0] x);
    logic [63:0] acc;
    acc = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    return acc;
  endfunction

endpackage

// ===== design/srfh_front.sv =====
`timescale 1ns / 1ps

module srfh_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic [srfh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                        cfg_data,
  input  logic                               item_valid,
  input  srfh_pkg::item_t                    item,
  input  logic                               queue_full,
  output logic                               push_valid,
  output srfh_pkg::work_t                    push_data
);

  logic [31:0] tight_row_bytes;
  logic [31:0] padded_row_bytes;
  logic [31:0] row_count;

  logic [31:0] column_position;
  logic [31:0] row_position;
  logic        overrun_flag;

  logic        accept;
  logic        take;
  logic        wrap;
  logic [31:0] column_next;
  logic [31:0] row_next;
  logic        overrun_next;
  logic        mismatch;

  assign accept = item_valid && !queue_full;

  always_comb begin
    take = row_position < row_count;
    // column+1 in 33 bits also covers the all-ones column
    wrap = ({1'b0, column_position} + 33'd1) >= {1'b0, padded_row_bytes};
    column_next = column_position;
    row_next = row_position;
    overrun_next = overrun_flag;
    if (take) begin
      if (wrap) begin
        column_next = 32'd0;
        row_next = row_position + 32'd1;
      end else begin
        column_next = column_position + 32'd1;
      end
    end else begin
      overrun_next = 1'b1;
    end
    mismatch = overrun_next || (row_next != row_count) || (column_next != 32'd0);
  end

  assign push_valid = item_valid;
  assign push_data.data_byte = item.data_byte;
  assign push_data.hash_en = take && (column_position < tight_row_bytes);
  assign push_data.last_byte = item.last_byte;
  assign push_data.length_mismatch = mismatch;

  always_ff @(posedge clk) begin
    if (rst) begin
      tight_row_bytes <= srfh_pkg::TIGHT_ROW_BYTES_RST;
      padded_row_bytes <= srfh_pkg::PADDED_ROW_BYTES_RST;
      row_count <= srfh_pkg::ROW_COUNT_RST;
      column_position <= 32'd0;
      row_position <= 32'd0;
      overrun_flag <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          srfh_pkg::CFG_TIGHT_ROW_BYTES: tight_row_bytes <= cfg_data;
          srfh_pkg::CFG_PADDED_ROW_BYTES: padded_row_bytes <= cfg_data;
          srfh_pkg::CFG_ROW_COUNT: row_count <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        if (item.last_byte) begin
          column_position <= 32'd0;
          row_position <= 32'd0;
          overrun_flag <= 1'b0;
        end else begin
          column_position <= column_next;
          row_position <= row_next;
          overrun_flag <= overrun_next;
        end
      end
    end
  end

  // buffer end must leave a clean stream state
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    accept && item.last_byte |=>
      column_position == 32'd0 && row_position == 32'd0 && !overrun_flag)
    else $error("stream state not cleared after last byte");

endmodule

// ===== design/srfh_queue.sv =====
`timescale 1ns / 1ps

module srfh_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  input  srfh_pkg::work_t push_data,
  output logic            full,
  input  logic            pop_ready,
  output logic            pop_valid,
  output srfh_pkg::work_t pop_data
);

  srfh_pkg::work_t entries [srfh_pkg::QDEPTH];

  logic [srfh_pkg::QPTR_W-1:0] wr_ptr;
  logic [srfh_pkg::QPTR_W-1:0] rd_ptr;
  logic [srfh_pkg::QCNT_W-1:0] count;
  logic                        push;
  logic                        pop;

  assign full = count == srfh_pkg::QCNT_W'(srfh_pkg::QDEPTH);
  assign pop_valid = count != '0;
  assign pop_data = entries[rd_ptr];
  assign push = push_valid && !full;
  assign pop = pop_valid && pop_ready;

  function automatic logic [srfh_pkg::QPTR_W-1:0] ptr_inc(
    input logic [srfh_pkg::QPTR_W-1:0] p
  );
    logic [srfh_pkg::QPTR_W-1:0] r;
    if (p == srfh_pkg::QPTR_W'(srfh_pkg::QDEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + srfh_pkg::QPTR_W'(1);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({push, pop})
        2'b10: count <= count + srfh_pkg::QCNT_W'(1);
        2'b01: count <= count - srfh_pkg::QCNT_W'(1);
        default: ;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= srfh_pkg::QCNT_W'(srfh_pkg::QDEPTH))
    else $error("queue count above depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> wr_ptr == rd_ptr)
    else $error("queue pointers apart while empty");

endmodule

// ===== design/srfh_back.sv =====
`timescale 1ns / 1ps

module srfh_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              pop_valid,
  input  srfh_pkg::work_t   pop_data,
  output logic              pop_ready,
  output logic              result_valid,
  input  logic              result_stall,
  output srfh_pkg::result_t result
);

  logic [63:0] running_hash;
  logic [63:0] hash_next;
  logic        fire;

  // only a last byte has to wait for the result register to free up
  assign pop_ready = !result_valid || !result_stall || !pop_data.last_byte;
  assign fire = pop_valid && pop_ready;

  always_comb begin
    hash_next = running_hash;
    if (pop_data.hash_en) begin
      hash_next = srfh_pkg::fnv_mul(running_hash ^ {56'd0, pop_data.data_byte});
    end
  end

  always_ff @(posedge clk) begin
    if (fire && pop_data.last_byte) begin
      result.payload_hash <= (hash_next == 64'd0) ? 64'd1 : hash_next;
      result.length_mismatch <= pop_data.length_mismatch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= srfh_pkg::FNV_OFFSET_BASIS;
      result_valid <= 1'b0;
    end else begin
      if (fire) begin
        running_hash <= pop_data.last_byte ? srfh_pkg::FNV_OFFSET_BASIS : hash_next;
      end
      if (fire && pop_data.last_byte) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  a_hash_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.payload_hash != 64'd0)
    else $error("zero hash delivered");

  a_basis_after_last: assert property (@(posedge clk) disable iff (rst)
    fire && pop_data.last_byte |=> running_hash == srfh_pkg::FNV_OFFSET_BASIS)
    else $error("hash not restarted after last byte");

endmodule

// ===== design/strided_row_fnv1a64_hash_top.sv =====
`timescale 1ns / 1ps

// Strided-row FNV-1a 64 hash. Takes one byte of a padded staging buffer per
// transfer on item, tracking column and row against the configured tight row
// length and row pitch; bytes in the tight part of each row, within row_count
// rows, are hashed. On the byte marked last_byte one result is produced: the
// hash (zero reported as one) and length_mismatch, set when the byte count is
// not row_count * padded_row_bytes. It takes one byte every cycle while
// item_stall is low, bounded by the combinational shift-add FNV multiply;
// the last byte is queued, and once popped sets the registered result_valid.
// A two-entry queue decouples position tracking from hashing; a stalled
// result holds back only the next last byte. Registers: 0 tight_row_bytes,
// 1 padded_row_bytes, 2 row_count; write them only between buffers.

module strided_row_fnv1a64_hash_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  srfh_pkg::item_t                item,
  output logic                           result_valid,
  input  logic                           result_stall,
  output srfh_pkg::result_t              result,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [srfh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);

  logic            queue_full;
  logic            push_valid;
  srfh_pkg::work_t push_data;
  logic            pop_valid;
  logic            pop_ready;
  srfh_pkg::work_t pop_data;

  assign cfg_ready = 1'b1;
  assign item_stall = queue_full;

  srfh_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .queue_full (queue_full),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  srfh_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .full       (queue_full),
    .pop_ready  (pop_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data)
  );

  srfh_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_data     (pop_data),
    .pop_ready    (pop_ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
